// ----- rtl/core/hwe_pkg.sv -----
// shared types and constants for the hyphenated word extractor
`timescale 1ns / 1ps
package hwe_pkg;

  localparam int WORD_MAX   = 63;
  localparam int LEN_W      = $clog2(WORD_MAX + 1);
  localparam int ADDR_W     = LEN_W + 1;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  typedef enum logic [1:0] {
    MODE_NORMAL       = 2'd0,
    MODE_AFTER_HYPHEN = 2'd1,
    MODE_SKIP_BLANKS  = 2'd2
  } scan_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_WORD    = 2'd1,
    BK_NEWLINE = 2'd2
  } back_state_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  function automatic logic is_letter(input logic [7:0] v);
    return v inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

endpackage

// ----- rtl/core/hwe_front.sv -----
// input scanner: classifies bytes, fills the word store and queues joined words
`timescale 1ns / 1ps
module hwe_front
  import hwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output wr_t        wr,
  output logic       push,
  output job_t       push_job,
  input  logic       q_full,
  input  rel_t       release_bank
);

  scan_mode_t       mode, mode_next;
  logic             joined, joined_next;
  logic [LEN_W-1:0] len, len_next;
  logic             cur_bank, cur_bank_next;
  logic [1:0]       bank_busy, bank_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      joined    <= 1'b0;
      len       <= '0;
      cur_bank  <= 1'b0;
      bank_busy <= 2'b00;
    end else begin
      mode      <= mode_next;
      joined    <= joined_next;
      len       <= len_next;
      cur_bank  <= cur_bank_next;
      bank_busy <= bank_busy_next;
    end
  end

  always_comb begin
    logic       accept;
    logic       do_store;
    logic       do_clear;
    logic [7:0] v;
    accept         = 1'b0;
    do_store       = 1'b0;
    do_clear       = 1'b0;
    v              = s_tdata;
    mode_next      = mode;
    joined_next    = joined;
    len_next       = len;
    cur_bank_next  = cur_bank;
    bank_busy_next = bank_busy;
    push           = 1'b0;
    push_job.bank  = cur_bank;
    push_job.len   = len;
    wr.en          = 1'b0;
    wr.addr        = {cur_bank, len};
    wr.data        = v;

    s_tready = !bank_busy[cur_bank] && !q_full;
    accept   = s_tvalid && s_tready;

    if (accept) begin
      if (v == CH_NUL) begin
        do_clear = 1'b1;
      end else begin
        case (mode)
          MODE_AFTER_HYPHEN: begin
            if (v == CH_NL) begin
              if (len == LEN_W'(1)) begin
                do_clear = 1'b1;
              end else begin
                joined_next = 1'b1;
                mode_next   = MODE_SKIP_BLANKS;
              end
            end else begin
              do_store  = 1'b1;
              mode_next = MODE_NORMAL;
            end
          end
          MODE_SKIP_BLANKS: begin
            if (!(v inside {CH_SPACE, CH_TAB, CH_NL})) begin
              do_store  = 1'b1;
              mode_next = MODE_NORMAL;
            end
          end
          default: begin
            mode_next = MODE_NORMAL;
            if (is_letter(v)) begin
              do_store = 1'b1;
            end else if (v == CH_HYPHEN) begin
              do_store  = 1'b1;
              mode_next = MODE_AFTER_HYPHEN;
            end else begin
              // word ends, a joined word goes to the emitter
              if (joined) begin
                push                     = 1'b1;
                cur_bank_next            = ~cur_bank;
                bank_busy_next[cur_bank] = 1'b1;
              end
              do_clear = 1'b1;
            end
          end
        endcase
      end
    end

    if (do_store && (len < LEN_W'(WORD_MAX))) begin
      wr.en    = 1'b1;
      len_next = len + LEN_W'(1);
    end

    if (do_clear) begin
      mode_next   = MODE_NORMAL;
      joined_next = 1'b0;
      len_next    = '0;
    end

    if (release_bank.en) begin
      bank_busy_next[release_bank.bank] = 1'b0;
    end
  end

endmodule

// ----- rtl/core/hwe_jobq.sv -----
// short queue of finished joined words between scanner and emitter
`timescale 1ns / 1ps
module hwe_jobq
  import hwe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic job_valid,
  output job_t job
);

  job_t                  entries [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wptr, rptr;
  logic [JOBQ_CNT_W-1:0] count;
  logic                  do_push, do_pop;

  assign full      = (count == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign job_valid = (count != '0);
  assign job       = entries[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wptr + JOBQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rptr + JOBQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + JOBQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - JOBQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/hwe_back.sv -----
// emitter: holds the two-bank word store and streams out queued words
`timescale 1ns / 1ps
module hwe_back
  import hwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  wr_t        wr,
  input  logic       job_valid,
  input  job_t       job,
  output logic       pop,
  output rel_t       release_bank,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_word
);

  logic [7:0] mem [2**ADDR_W];

  back_state_t      state, state_next;
  logic             ov, ov_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] len, len_next;
  logic             bank, bank_next;
  logic             out_last, out_last_next;
  logic [7:0]       out_byte;
  logic             rd_en, nl_load, can_load;
  logic [ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_byte <= mem[rd_addr];
    end else if (nl_load) begin
      out_byte <= CH_NL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      ov       <= 1'b0;
      idx      <= '0;
      len      <= '0;
      bank     <= 1'b0;
      out_last <= 1'b0;
    end else begin
      state    <= state_next;
      ov       <= ov_next;
      idx      <= idx_next;
      len      <= len_next;
      bank     <= bank_next;
      out_last <= out_last_next;
    end
  end

  assign can_load = !ov || m_tready;
  assign rd_addr  = {bank, idx};

  always_comb begin
    state_next        = state;
    ov_next           = ov;
    idx_next          = idx;
    len_next          = len;
    bank_next         = bank;
    out_last_next     = out_last;
    pop               = 1'b0;
    rd_en             = 1'b0;
    nl_load           = 1'b0;
    release_bank.en   = 1'b0;
    release_bank.bank = bank;
    case (state)
      BK_IDLE: begin
        if (can_load) begin
          ov_next = 1'b0;
          if (job_valid) begin
            pop        = 1'b1;
            bank_next  = job.bank;
            len_next   = job.len;
            idx_next   = '0;
            state_next = BK_WORD;
          end
        end
      end
      BK_WORD: begin
        if (can_load) begin
          ov_next = 1'b1;
          if (idx != len) begin
            rd_en         = 1'b1;
            out_last_next = 1'b0;
            idx_next      = idx + LEN_W'(1);
          end else begin
            nl_load       = 1'b1;
            out_last_next = 1'b1;
            state_next    = BK_NEWLINE;
          end
        end
      end
      BK_NEWLINE: begin
        if (can_load) begin
          ov_next         = 1'b0;
          release_bank.en = 1'b1;
          state_next      = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
        ov_next    = 1'b0;
      end
    endcase
  end

  assign m_tvalid = ov;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

// ----- rtl/core/hyphenated_word_extractor_core.sv -----
// top level of the hyphenated word extractor
// input: one byte per cycle; stalls only while a second joined word ends before the
//   previous one has drained from the other store bank
// output: a joined word of n stored bytes leaves as n + 1 transactions, one per
//   cycle while m_tready is high, the first once its job is popped and its store read
// reset: synchronous; clears scan state, queue and emitter, the word store is not cleared
`timescale 1ns / 1ps
module hyphenated_word_extractor_core
  import hwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_word
);

  wr_t  wr;
  logic push, q_full, pop, job_valid;
  job_t push_job, job;
  rel_t release_bank;

  hwe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .wr           (wr),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full),
    .release_bank (release_bank)
  );

  hwe_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job)
  );

  hwe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .job_valid    (job_valid),
    .job          (job),
    .pop          (pop),
    .release_bank (release_bank),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

// ----- rtl/core/hwe_checker.sv -----
// port checker for the hyphenated word extractor
`timescale 1ns / 1ps
module hwe_checker
  import hwe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_last_newline: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == CH_NL)
    else $error("word end is not a newline");

  a_word_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata != CH_NUL)
    else $error("word byte is zero");

endmodule

bind hyphenated_word_extractor_core hwe_checker u_hwe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- tb/tb_hyphenated_word_extractor_core.sv -----
// self-checking testbench for the hyphenated word extractor core
`timescale 1ns / 1ps
module tb_hyphenated_word_extractor_core;
  import hwe_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;

  word_beat_t joined_word_q[$];
  scan_mode_t sc_mode;
  logic       sc_joined;
  int         sc_len;
  logic [7:0] sc_word[WORD_MAX];
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         idle_pct = 31;
  int         stall_cycles = 0;

  hyphenated_word_extractor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic is_word_char(input logic [7:0] b);
    logic [7:0] folded;
    folded = b | 8'h20;
    return (folded >= CH_LO_A) && (folded <= CH_LO_Z);
  endfunction

  function automatic void clear_scan();
    sc_mode   = MODE_NORMAL;
    sc_joined = 1'b0;
    sc_len    = 0;
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    if (sc_len < WORD_MAX) begin
      sc_word[sc_len] = b;
      sc_len++;
    end
  endfunction

  // expected output for one accepted text byte
  function automatic void extract_joined_word(input logic [7:0] b);
    if (b == CH_NUL) begin
      clear_scan();
      return;
    end
    case (sc_mode)
      MODE_AFTER_HYPHEN: begin
        if (b == CH_NL) begin
          if (sc_len == 1) begin
            clear_scan();
          end else begin
            sc_joined = 1'b1;
            sc_mode   = MODE_SKIP_BLANKS;
          end
        end else begin
          keep_byte(b);
          sc_mode = MODE_NORMAL;
        end
      end
      MODE_SKIP_BLANKS: begin
        if (b != CH_SPACE && b != CH_TAB && b != CH_NL) begin
          keep_byte(b);
          sc_mode = MODE_NORMAL;
        end
      end
      default: begin
        sc_mode = MODE_NORMAL;
        if (is_word_char(b)) begin
          keep_byte(b);
        end else if (b == CH_HYPHEN) begin
          keep_byte(b);
          sc_mode = MODE_AFTER_HYPHEN;
        end else begin
          if (sc_joined) begin
            for (int k = 0; k < sc_len; k++) joined_word_q.push_back('{sc_word[k], 1'b0});
            joined_word_q.push_back('{CH_NL, 1'b1});
          end
          clear_scan();
        end
      end
    endcase
  endfunction

  // prediction on input transactions, checking on output transactions
  always @(posedge clk) begin
    word_beat_t want;
    if (rst) begin
      clear_scan();
    end else begin
      if (s_tvalid && s_tready) extract_joined_word(s_tdata);
      if (m_tvalid && m_tready) begin
        if (joined_word_q.size() == 0) begin
          $error("unexpected output transaction: out_byte %h last_of_word %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = joined_word_q.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte expected %h actual %h", want.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_word expected %b actual %b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_hyphenated_word_extractor_core: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (joined_word_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return CH_LO_A + 8'($urandom_range(0, 25));
    return CH_UP_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] rand_delim();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 3) == 0) b = rand_blank();
    if (is_word_char(b) || b == CH_HYPHEN) b = CH_SPACE;
    return b;
  endfunction

  task automatic send_letters(input int n);
    repeat (n) send_byte(rand_letter());
  endtask

  task automatic test_directed();
    send_text("ab-\n \tcd.");
    // lone hyphen, then a word ended by a newline
    send_text("-\nx\n");
    // hyphen stored raw as first byte after the blanks
    send_text("Z-\n\n-Q ");
    send_text("y-\n");
    send_byte(8'hff);
    send_byte(8'h2c);
    // end of input after a hyphen and while skipping blanks
    send_text("a-");
    send_byte(CH_NUL);
    send_text("k-\n");
    send_byte(CH_NUL);
  endtask

  task automatic test_full_store();
    send_letters(30);
    send_byte(CH_HYPHEN);
    send_byte(CH_NL);
    send_byte(rand_blank());
    send_letters(40);
    send_byte(rand_delim());
    wait_drained();
    send_letters(61);
    send_byte(CH_HYPHEN);
    send_byte(CH_NL);
    send_letters(3);
    send_byte(CH_SPACE);
  endtask

  task automatic test_random(input int n_items);
    int target;
    int pick;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_letters($urandom_range(1, 6));
        send_byte(CH_HYPHEN);
        send_byte(CH_NL);
        repeat ($urandom_range(0, 3)) send_byte(rand_blank());
        if ($urandom_range(0, 4) == 0) begin
          send_byte(8'($urandom_range(0, 255)));
        end
        send_letters($urandom_range(0, 6));
        send_byte(rand_delim());
      end else if (pick < 68) begin
        send_letters($urandom_range(1, 8));
        send_byte(rand_delim());
      end else if (pick < 78) begin
        send_letters($urandom_range(0, 4));
        send_byte(CH_HYPHEN);
        send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_byte(rand_delim());
      end else if (pick < 86) begin
        send_byte(CH_HYPHEN);
        send_byte(CH_NL);
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        wait_drained();
      end
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(70);
    idle_pct = 31;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    wait_drained();
    test_full_store();
    test_no_idle();
    test_random(230);
    s_tvalid <= 1'b0;
    while (joined_word_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_hyphenated_word_extractor_core: PASS");
    end else begin
      $display("tb_hyphenated_word_extractor_core: FAIL");
    end
    $finish;
  end

endmodule
